FILE: rtl/core/pisf_pkg.sv
// ----------------------------------------------------------------------------
// pisf_pkg
// Types, register indexes and saturating helpers shared by the force unit.
// ----------------------------------------------------------------------------
package pisf_pkg;

    localparam logic [2:0] REG_GRAVITY     = 3'd0;
    localparam logic [2:0] REG_SELF_RANGE  = 3'd1;
    localparam logic [2:0] REG_OTHER_RANGE = 3'd2;
    localparam logic [2:0] REG_SELF_COEF   = 3'd3;
    localparam logic [2:0] REG_OTHER_COEF  = 3'd4;

    localparam logic ACT_LOAD = 1'b0;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } alu_stat_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQX,
        S_SQY,
        S_SQRT,
        S_DIVF,
        S_DIVX,
        S_DIVY,
        S_MFX,
        S_MFY,
        S_MSX,
        S_MSY,
        S_MOX,
        S_MOY,
        S_EMIT_O,
        S_EMIT_S
    } state_t;

    typedef struct packed {
        logic [31:0] v;
        logic        s;
    } sat_t;

    function automatic logic [31:0] mag32(input logic [31:0] v);
        logic [31:0] r;
        begin
            r = v[31] ? (32'd0 - v) : v;
            return r;
        end
    endfunction

    // signed value from sign and magnitude, clipped to 32 bits
    function automatic sat_t from_mag(input logic neg, input logic [63:0] m);
        sat_t        r;
        logic [31:0] mm;
        begin
            r.s = 1'b0;
            if (m > 64'h8000_0000)
            begin
                r.s = 1'b1;
                mm  = 32'h8000_0000;
            end
            else
            begin
                mm = m[31:0];
            end
            if (neg)
            begin
                r.v = 32'd0 - mm;
            end
            else if (mm == 32'h8000_0000)
            begin
                r.s = 1'b1;
                r.v = 32'h7FFF_FFFF;
            end
            else
            begin
                r.v = mm;
            end
            return r;
        end
    endfunction

    function automatic sat_t sat_add(input logic [31:0] a, input logic [31:0] b,
                                     input logic sub);
        sat_t        r;
        logic [32:0] sum;
        begin
            if (sub)
                sum = {a[31], a} - {b[31], b};
            else
                sum = {a[31], a} + {b[31], b};
            if (sum[32] != sum[31])
            begin
                r.s = 1'b1;
                r.v = sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end
            else
            begin
                r.s = 1'b0;
                r.v = sum[31:0];
            end
            return r;
        end
    endfunction

endpackage

FILE: rtl/core/pisf_serial_alu.sv
// ----------------------------------------------------------------------------
// pisf_serial_alu
// Bit-serial multiply, restoring divide and square root on shared shift regs.
// ----------------------------------------------------------------------------
module pisf_serial_alu
    import pisf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  alu_ctrl_t   ctrl,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output alu_stat_t   stat,
    output logic [63:0] result
);

    logic [63:0] acc_reg, acc_next;
    logic [63:0] x_reg, x_next;
    logic [63:0] y_reg, y_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    alu_op_t     op_reg, op_next;

    logic [64:0] div_r;
    logic [34:0] sq_r;
    logic [34:0] sq_t;

    always_comb
    begin
        acc_next  = acc_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        op_next   = op_reg;
        done_next = 1'b0;
        div_r     = {acc_reg, x_reg[63]};
        sq_r      = {acc_reg[32:0], x_reg[63:62]};
        sq_t      = {1'b0, y_reg[31:0], 2'b01};
        if (ctrl.start)
        begin
            op_next   = ctrl.op;
            busy_next = 1'b1;
            acc_next  = 64'd0;
            unique case (ctrl.op)
                OP_MUL:
                begin
                    x_next   = {32'd0, a[31:0]};
                    y_next   = {32'd0, b[31:0]};
                    cnt_next = 7'd31;
                end
                OP_DIV:
                begin
                    x_next   = a;
                    y_next   = b;
                    cnt_next = 7'd63;
                end
                default:
                begin
                    x_next   = a;
                    y_next   = 64'd0;
                    cnt_next = 7'd31;
                end
            endcase
        end
        else if (busy_reg)
        begin
            unique case (op_reg)
                OP_MUL:
                begin
                    if (y_reg[0])
                        acc_next = acc_reg + x_reg;
                    x_next = {x_reg[62:0], 1'b0};
                    y_next = {1'b0, y_reg[63:1]};
                end
                OP_DIV:
                begin
                    if (div_r >= {1'b0, y_reg})
                    begin
                        acc_next = 64'(div_r - {1'b0, y_reg});
                        x_next   = {x_reg[62:0], 1'b1};
                    end
                    else
                    begin
                        acc_next = div_r[63:0];
                        x_next   = {x_reg[62:0], 1'b0};
                    end
                end
                default:
                begin
                    // one root bit per step from the next pair of radicand bits
                    if (sq_r >= sq_t)
                    begin
                        acc_next = {29'd0, sq_r - sq_t};
                        y_next   = {y_reg[62:0], 1'b1};
                    end
                    else
                    begin
                        acc_next = {29'd0, sq_r};
                        y_next   = {y_reg[62:0], 1'b0};
                    end
                    x_next = {x_reg[61:0], 2'b00};
                end
            endcase
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= OP_MUL;
            cnt_reg  <= 7'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
    end

    always_comb
    begin
        unique case (op_reg)
            OP_MUL:  result = acc_reg;
            OP_DIV:  result = x_reg;
            default: result = y_reg;
        endcase
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

FILE: rtl/core/pairwise_inverse_square_force_unit.sv
// ----------------------------------------------------------------------------
// pairwise_inverse_square_force_unit
// Q16.16 pairwise inverse-square interaction between a stored subject
// particle and a stream of other particles, with saturating arithmetic.
// ----------------------------------------------------------------------------
// channel   handshake                 payload
// item      item_valid / item_ready   action, pos_x, pos_y, vel_x, vel_y, last
// result    result_valid / result_ready  out_vel_x, out_vel_y, is_subject,
//                                     saturated, end_of_run
// cfg       cfg_valid / cfg_ready     cfg_index, cfg_data
//
// a load transaction is taken in the idle state; an interact transaction runs on
// the one bit-per-cycle serial unit (squares, root, three 64-step divides,
// products) and skips the divides and products at zero distance
// rst_n clears the subject to zero and the configuration registers to their defaults
// the next transaction is taken while a result still waits in the output reg
// a stalled result holds the unit in its emit state until it is taken
// ----------------------------------------------------------------------------
module pairwise_inverse_square_force_unit
    import pisf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic        action,
    input  logic [31:0] pos_x,
    input  logic [31:0] pos_y,
    input  logic [31:0] vel_x,
    input  logic [31:0] vel_y,
    input  logic        last,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [31:0] out_vel_x,
    output logic [31:0] out_vel_y,
    output logic        is_subject,
    output logic        saturated,
    output logic        end_of_run,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    state_t      state_reg, state_next;
    logic        issue_reg, issue_next;
    alu_ctrl_t   alu_ctrl;
    alu_stat_t   alu_stat;
    logic [63:0] alu_a, alu_b, alu_res;

    logic [31:0] gravity_reg, self_coef_reg, other_coef_reg;
    logic [30:0] self_range_reg, other_range_reg;
    logic [31:0] spx_reg, spy_reg, svx_reg, svy_reg;
    logic        subj_clip_reg;

    logic [31:0] vx_reg, vy_reg, dx_reg, dy_reg;
    logic        last_reg, pair_s_reg, term_s_reg, oth_s_reg;
    logic [63:0] d2_reg;
    logic [31:0] dist_reg, f_reg, ux_reg, uy_reg, fx_reg, fy_reg, tx_reg;

    logic        out_valid_reg;
    logic [31:0] out_vx_reg, out_vy_reg;
    logic        out_subj_reg, out_sat_reg, out_end_reg;

    logic        item_take, out_free, self_hit, other_hit;
    logic        div_neg, mul_neg;
    sat_t        dx_in, dy_in, fm_div, fm_mul, add_x, add_y;

    pisf_serial_alu u_alu
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (alu_ctrl),
        .a      (alu_a),
        .b      (alu_b),
        .stat   (alu_stat),
        .result (alu_res)
    );

    assign item_ready = (state_reg == S_IDLE);
    assign item_take  = item_valid && item_ready;
    assign cfg_ready  = 1'b1;
    assign out_free   = !out_valid_reg || result_ready;
    assign self_hit   = {1'b0, dist_reg} < {2'b00, self_range_reg};
    assign other_hit  = {1'b0, dist_reg} < {2'b00, other_range_reg};

    assign dx_in = sat_add(spx_reg, pos_x, 1'b1);
    assign dy_in = sat_add(spy_reg, pos_y, 1'b1);

    always_comb
    begin
        priority case (state_reg)
            S_DIVF:  div_neg = gravity_reg[31];
            S_DIVX:  div_neg = dx_reg[31];
            default: div_neg = dy_reg[31];
        endcase
        priority case (state_reg)
            S_MFX:   mul_neg = f_reg[31] ^ ux_reg[31];
            S_MFY:   mul_neg = f_reg[31] ^ uy_reg[31];
            S_MSX:   mul_neg = fx_reg[31] ^ self_coef_reg[31];
            S_MSY:   mul_neg = fy_reg[31] ^ self_coef_reg[31];
            S_MOX:   mul_neg = fx_reg[31] ^ other_coef_reg[31];
            default: mul_neg = fy_reg[31] ^ other_coef_reg[31];
        endcase
    end

    assign fm_div = from_mag(div_neg, alu_res);
    assign fm_mul = from_mag(mul_neg, {16'd0, alu_res[63:16]});
    assign add_x  = (state_reg == S_MSY) ? sat_add(svx_reg, tx_reg, 1'b0)
                                         : sat_add(vx_reg, tx_reg, 1'b1);
    assign add_y  = (state_reg == S_MSY) ? sat_add(svy_reg, fm_mul.v, 1'b0)
                                         : sat_add(vy_reg, fm_mul.v, 1'b1);

    // next state, serial unit operands
    always_comb
    begin
        state_next   = state_reg;
        issue_next   = 1'b0;
        alu_ctrl.start = issue_reg;
        alu_ctrl.op  = OP_MUL;
        alu_a        = 64'd0;
        alu_b        = 64'd0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_take && action != ACT_LOAD)
                begin
                    state_next = S_SQX;
                    issue_next = 1'b1;
                end
            end
            S_SQX:
            begin
                alu_a = {32'd0, mag32(dx_reg)};
                alu_b = {32'd0, mag32(dx_reg)};
                if (alu_stat.done)
                begin
                    state_next = S_SQY;
                    issue_next = 1'b1;
                end
            end
            S_SQY:
            begin
                alu_a = {32'd0, mag32(dy_reg)};
                alu_b = {32'd0, mag32(dy_reg)};
                if (alu_stat.done)
                begin
                    state_next = S_SQRT;
                    issue_next = 1'b1;
                end
            end
            S_SQRT:
            begin
                alu_ctrl.op = OP_SQRT;
                alu_a       = d2_reg;
                if (alu_stat.done)
                begin
                    if (d2_reg == 64'd0)
                        state_next = S_EMIT_O;
                    else
                    begin
                        state_next = S_DIVF;
                        issue_next = 1'b1;
                    end
                end
            end
            S_DIVF:
            begin
                alu_ctrl.op = OP_DIV;
                alu_a       = {mag32(gravity_reg), 32'd0};
                alu_b       = d2_reg;
                if (alu_stat.done)
                begin
                    state_next = S_DIVX;
                    issue_next = 1'b1;
                end
            end
            S_DIVX:
            begin
                alu_ctrl.op = OP_DIV;
                alu_a       = {16'd0, mag32(dx_reg), 16'd0};
                alu_b       = {32'd0, dist_reg};
                if (alu_stat.done)
                begin
                    state_next = S_DIVY;
                    issue_next = 1'b1;
                end
            end
            S_DIVY:
            begin
                alu_ctrl.op = OP_DIV;
                alu_a       = {16'd0, mag32(dy_reg), 16'd0};
                alu_b       = {32'd0, dist_reg};
                if (alu_stat.done)
                begin
                    state_next = S_MFX;
                    issue_next = 1'b1;
                end
            end
            S_MFX:
            begin
                alu_a = {32'd0, mag32(f_reg)};
                alu_b = {32'd0, mag32(ux_reg)};
                if (alu_stat.done)
                begin
                    state_next = S_MFY;
                    issue_next = 1'b1;
                end
            end
            S_MFY:
            begin
                alu_a = {32'd0, mag32(f_reg)};
                alu_b = {32'd0, mag32(uy_reg)};
                if (alu_stat.done)
                begin
                    priority if (self_hit)
                    begin
                        state_next = S_MSX;
                        issue_next = 1'b1;
                    end
                    else if (other_hit)
                    begin
                        state_next = S_MOX;
                        issue_next = 1'b1;
                    end
                    else
                        state_next = S_EMIT_O;
                end
            end
            S_MSX:
            begin
                alu_a = {32'd0, mag32(fx_reg)};
                alu_b = {32'd0, mag32(self_coef_reg)};
                if (alu_stat.done)
                begin
                    state_next = S_MSY;
                    issue_next = 1'b1;
                end
            end
            S_MSY:
            begin
                alu_a = {32'd0, mag32(fy_reg)};
                alu_b = {32'd0, mag32(self_coef_reg)};
                if (alu_stat.done)
                begin
                    if (other_hit)
                    begin
                        state_next = S_MOX;
                        issue_next = 1'b1;
                    end
                    else
                        state_next = S_EMIT_O;
                end
            end
            S_MOX:
            begin
                alu_a = {32'd0, mag32(fx_reg)};
                alu_b = {32'd0, mag32(other_coef_reg)};
                if (alu_stat.done)
                begin
                    state_next = S_MOY;
                    issue_next = 1'b1;
                end
            end
            S_MOY:
            begin
                alu_a = {32'd0, mag32(fy_reg)};
                alu_b = {32'd0, mag32(other_coef_reg)};
                if (alu_stat.done)
                    state_next = S_EMIT_O;
            end
            S_EMIT_O:
            begin
                if (out_free)
                    state_next = last_reg ? S_EMIT_S : S_IDLE;
            end
            default:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            issue_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            issue_reg <= issue_next;
        end
    end

    // configuration, subject state and output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gravity_reg     <= 32'h0001_0000;
            self_range_reg  <= 31'd6553600;
            other_range_reg <= 31'd6553600;
            self_coef_reg   <= 32'h0001_0000;
            other_coef_reg  <= 32'h0001_0000;
            spx_reg         <= 32'd0;
            spy_reg         <= 32'd0;
            svx_reg         <= 32'd0;
            svy_reg         <= 32'd0;
            subj_clip_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_GRAVITY:     gravity_reg     <= cfg_data;
                    REG_SELF_RANGE:  self_range_reg  <= cfg_data[30:0];
                    REG_OTHER_RANGE: other_range_reg <= cfg_data[30:0];
                    REG_SELF_COEF:   self_coef_reg   <= cfg_data;
                    REG_OTHER_COEF:  other_coef_reg  <= cfg_data;
                    default:         ;
                endcase
            end
            if (item_take && action == ACT_LOAD)
            begin
                spx_reg       <= pos_x;
                spy_reg       <= pos_y;
                svx_reg       <= vel_x;
                svy_reg       <= vel_y;
                subj_clip_reg <= 1'b0;
            end
            if (state_reg == S_MSY && alu_stat.done)
            begin
                svx_reg <= add_x.v;
                svy_reg <= add_y.v;
                if (term_s_reg || fm_mul.s || add_x.s || add_y.s)
                    subj_clip_reg <= 1'b1;
            end
            if ((state_reg == S_EMIT_O || state_reg == S_EMIT_S) && out_free)
                out_valid_reg <= 1'b1;
            else if (result_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // per-pair working registers and output data registers
    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            vx_reg     <= vel_x;
            vy_reg     <= vel_y;
            last_reg   <= last;
            dx_reg     <= dx_in.v;
            dy_reg     <= dy_in.v;
            pair_s_reg <= dx_in.s || dy_in.s;
            oth_s_reg  <= 1'b0;
        end
        if (alu_stat.done)
        begin
            unique case (state_reg)
                S_SQX:  d2_reg   <= alu_res;
                S_SQY:  d2_reg   <= d2_reg + alu_res;
                S_SQRT: dist_reg <= alu_res[31:0];
                S_DIVF:
                begin
                    f_reg      <= fm_div.v;
                    pair_s_reg <= pair_s_reg || fm_div.s;
                end
                S_DIVX:
                begin
                    ux_reg     <= fm_div.v;
                    pair_s_reg <= pair_s_reg || fm_div.s;
                end
                S_DIVY:
                begin
                    uy_reg     <= fm_div.v;
                    pair_s_reg <= pair_s_reg || fm_div.s;
                end
                S_MFX:
                begin
                    fx_reg     <= fm_mul.v;
                    pair_s_reg <= pair_s_reg || fm_mul.s;
                end
                S_MFY:
                begin
                    fy_reg     <= fm_mul.v;
                    pair_s_reg <= pair_s_reg || fm_mul.s;
                end
                S_MSX, S_MOX:
                begin
                    tx_reg     <= fm_mul.v;
                    term_s_reg <= pair_s_reg || fm_mul.s;
                end
                S_MOY:
                begin
                    vx_reg    <= add_x.v;
                    vy_reg    <= add_y.v;
                    oth_s_reg <= term_s_reg || fm_mul.s || add_x.s || add_y.s;
                end
                default: ;
            endcase
        end
        if (state_reg == S_EMIT_O && out_free)
        begin
            out_vx_reg   <= vx_reg;
            out_vy_reg   <= vy_reg;
            out_subj_reg <= 1'b0;
            out_sat_reg  <= oth_s_reg;
            out_end_reg  <= !last_reg;
        end
        else if (state_reg == S_EMIT_S && out_free)
        begin
            out_vx_reg   <= svx_reg;
            out_vy_reg   <= svy_reg;
            out_subj_reg <= 1'b1;
            out_sat_reg  <= subj_clip_reg;
            out_end_reg  <= 1'b1;
        end
    end

    assign result_valid = out_valid_reg;
    assign out_vel_x    = out_vx_reg;
    assign out_vel_y    = out_vy_reg;
    assign is_subject   = out_subj_reg;
    assign saturated    = out_sat_reg;
    assign end_of_run   = out_end_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        alu_ctrl.start |-> !alu_stat.busy)
        else $error("serial unit started while busy");

    a_done_no_start: assert property (@(posedge clk) disable iff (!rst_n)
        alu_stat.done |-> !alu_ctrl.start)
        else $error("serial unit done and start in the same cycle");

    a_subject_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EMIT_S |-> last_reg)
        else $error("subject result without last");

    a_clip_cleared_by_load: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(subj_clip_reg) |-> $past(item_take && action == ACT_LOAD))
        else $error("subject clip flag cleared without load");

endmodule
